@@ hw/rtl/vbfe_pkg.sv @@
// ============================================================================
// vbfe_pkg
// Shared widths, codes and the face job record of the boundary face extractor.
// ============================================================================
package vbfe_pkg;

   // Field widths fixed by the channel formats
   localparam int DIM_W    = 9;
   localparam int FACE_W   = 9;
   localparam int AXIS_W   = 2;
   localparam int CSR_IDX_W = 2;

   // Default for the largest volume edge
   localparam int MAX_DIM_DEFAULT = 256;

   // Dimension register value after reset
   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Z = 2'd2;

   // Face normal axis codes
   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   // Face slots of one voxel, in output order
   localparam int SLOT_N      = 6;
   localparam int SLOT_X_LOW  = 0;
   localparam int SLOT_X_HIGH = 1;
   localparam int SLOT_Y_LOW  = 2;
   localparam int SLOT_Y_HIGH = 3;
   localparam int SLOT_Z_LOW  = 4;
   localparam int SLOT_Z_HIGH = 5;

   // Job queue between classifier and face serialiser
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int QFILL_W     = 4;

   // One classified voxel: coordinates (already cut to the face width)
   // and one bit per face slot that must be sent
   typedef struct packed {
      logic [FACE_W-1:0] x;
      logic [FACE_W-1:0] y;
      logic [FACE_W-1:0] z;
      logic [SLOT_N-1:0] mask;
   } face_job_type;

   // Queue status seen by the classifier
   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              not_empty;
   } queue_status_type;

endpackage

@@ hw/rtl/vbfe_channels.sv @@
// ============================================================================
// vbfe_channels
// Valid/ready channel interfaces: voxel input, face output, register writes.
// ============================================================================
interface vbfe_req_if;
   logic valid;
   logic ready;
   logic solid;

   modport source (output valid, output solid, input ready);
   modport sink   (input valid, input solid, output ready);
endinterface

interface vbfe_rsp_if;
   import vbfe_pkg::*;
   logic              valid;
   logic              ready;
   logic [FACE_W-1:0] face_x;
   logic [FACE_W-1:0] face_y;
   logic [FACE_W-1:0] face_z;
   logic [AXIS_W-1:0] face_axis;
   logic              last_face;

   modport source (output valid, output face_x, output face_y, output face_z,
                   output face_axis, output last_face, input ready);
   modport sink   (input valid, input face_x, input face_y, input face_z,
                   input face_axis, input last_face, output ready);
endinterface

interface vbfe_csr_if;
   import vbfe_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/vbfe_front.sv @@
// ============================================================================
// vbfe_front
// Voxel intake: position counters, row and slice stores, face classification.
// ============================================================================
module vbfe_front #(
   parameter int MAX_DIM = vbfe_pkg::MAX_DIM_DEFAULT,
   parameter int CW      = $clog2(MAX_DIM)
) (
   input  logic                        clock,
   input  logic                        reset,
   vbfe_req_if.sink                    req,
   input  logic [CW-1:0]               last_x,
   input  logic [CW-1:0]               last_y,
   input  logic [CW-1:0]               last_z,
   input  vbfe_pkg::queue_status_type  q_status,
   output logic                        q_push,
   output vbfe_pkg::face_job_type      q_job
);
   import vbfe_pkg::*;

   localparam int SLICE_AW    = 2 * CW;
   localparam int SLICE_DEPTH = 1 << SLICE_AW;

   logic                  accept;
   logic [QFILL_W-1:0]    fill;
   logic [CW-1:0]         x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                  left_ff;
   logic [SLICE_AW-1:0]   slice_addr;

   logic                  row_mem   [MAX_DIM];
   logic                  slice_mem [SLICE_DEPTH];

   // stage one registers
   logic                  s1_valid_ff;
   logic                  s1_cur_ff;
   logic                  s1_left_ff;
   logic                  s1_row_ff;
   logic                  s1_slice_ff;
   logic                  s1_x0_ff, s1_y0_ff, s1_z0_ff;
   logic                  s1_hix_ff, s1_hiy_ff, s1_hiz_ff;
   logic [FACE_W-1:0]     s1_x_ff, s1_y_ff, s1_z_ff;

   logic                  nb_x, nb_y, nb_z;
   logic [SLOT_N-1:0]     mask;

   // room for the beat in flight plus a new one
   assign fill      = QFILL_W'(q_status.count) + QFILL_W'(s1_valid_ff);
   assign req.ready = (fill < QFILL_W'(QUEUE_DEPTH));
   assign accept    = req.valid & req.ready;

   assign slice_addr = {y_ff, x_ff};

   // raster position advance
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (x_ff >= last_x) begin
         x_in = '0;
         if (y_ff >= last_y) begin
            y_in = '0;
            z_in = (z_ff >= last_z) ? '0 : z_ff + CW'(1);
         end else begin
            y_in = y_ff + CW'(1);
         end
      end else begin
         x_in = x_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         z_ff        <= '0;
         left_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
            left_ff <= req.solid;
         end
      end
   end

   // row and slice stores: read old value, write the new voxel, same beat
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff   <= row_mem[x_ff];
         row_mem[x_ff] <= req.solid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_slice_ff <= slice_mem[slice_addr];
         slice_mem[slice_addr] <= req.solid;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff  <= req.solid;
         s1_left_ff <= left_ff;
         s1_x0_ff   <= (x_ff == '0);
         s1_y0_ff   <= (y_ff == '0);
         s1_z0_ff   <= (z_ff == '0);
         s1_hix_ff  <= (x_ff == last_x);
         s1_hiy_ff  <= (y_ff == last_y);
         s1_hiz_ff  <= (z_ff == last_z);
         s1_x_ff    <= FACE_W'(x_ff);
         s1_y_ff    <= FACE_W'(y_ff);
         s1_z_ff    <= FACE_W'(z_ff);
      end
   end

   // classify: low edges read as empty neighbours
   always_comb begin
      nb_x = s1_x0_ff ? 1'b0 : s1_left_ff;
      nb_y = s1_y0_ff ? 1'b0 : s1_row_ff;
      nb_z = s1_z0_ff ? 1'b0 : s1_slice_ff;
      mask = '0;
      mask[SLOT_X_LOW]  = s1_cur_ff ^ nb_x;
      mask[SLOT_X_HIGH] = s1_cur_ff & s1_hix_ff;
      mask[SLOT_Y_LOW]  = s1_cur_ff ^ nb_y;
      mask[SLOT_Y_HIGH] = s1_cur_ff & s1_hiy_ff;
      mask[SLOT_Z_LOW]  = s1_cur_ff ^ nb_z;
      mask[SLOT_Z_HIGH] = s1_cur_ff & s1_hiz_ff;
   end

   // voxels with no face never enter the queue
   assign q_push     = s1_valid_ff & (|mask);
   assign q_job.x    = s1_x_ff;
   assign q_job.y    = s1_y_ff;
   assign q_job.z    = s1_z_ff;
   assign q_job.mask = mask;

`ifndef ASSERT_OFF
   a_accept_to_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted voxel did not reach classification");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_status.count < QCNT_W'(QUEUE_DEPTH)))
      else $error("classifier pushed into a full queue");
`endif

endmodule

@@ hw/rtl/vbfe_queue.sv @@
// ============================================================================
// vbfe_queue
// Short job queue decoupling the classifier from the face serialiser.
// ============================================================================
module vbfe_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  vbfe_pkg::face_job_type      push_job,
   input  logic                        pop,
   output vbfe_pkg::face_job_type      head_job,
   output vbfe_pkg::queue_status_type  status
);
   import vbfe_pkg::*;

   face_job_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job         = slot_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff != QCNT_W'(QUEUE_DEPTH)))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job queue underflow");
`endif

endmodule

@@ hw/rtl/vbfe_back.sv @@
// ============================================================================
// vbfe_back
// Face serialiser: turns one job into its faces, one output beat each.
// ============================================================================
module vbfe_back (
   input  logic                        clock,
   input  logic                        reset,
   input  vbfe_pkg::face_job_type      head_job,
   input  vbfe_pkg::queue_status_type  q_status,
   output logic                        q_pop,
   vbfe_rsp_if.source                  rsp
);
   import vbfe_pkg::*;

   logic [SLOT_N-1:0]  mask_ff, mask_in;
   logic [FACE_W-1:0]  job_x_ff, job_y_ff, job_z_ff;
   logic [SLOT_N-1:0]  pick;
   logic [SLOT_N-1:0]  rest;
   logic               found;
   logic               out_free;
   logic               emit;

   logic               valid_ff;
   logic [FACE_W-1:0]  face_x_ff, face_y_ff, face_z_ff;
   logic [AXIS_W-1:0]  axis_ff;
   logic               last_ff;

   logic [FACE_W-1:0]  fx, fy, fz;
   logic [AXIS_W-1:0]  faxis;

   // lowest pending face slot goes first
   always_comb begin
      pick  = '0;
      found = 1'b0;
      for (int i = 0; i < SLOT_N; i++) begin
         if (!found && mask_ff[i]) begin
            pick[i] = 1'b1;
            found   = 1'b1;
         end
      end
   end

   assign rest     = mask_ff & ~pick;
   assign out_free = ~valid_ff | rsp.ready;
   assign emit     = out_free & (|mask_ff);
   assign q_pop    = q_status.not_empty & ((mask_ff == '0) | (emit & (rest == '0)));

   always_comb begin
      mask_in = mask_ff;
      if (q_pop) begin
         mask_in = head_job.mask;
      end else if (emit) begin
         mask_in = rest;
      end
   end

   // face position and axis for the chosen slot
   always_comb begin
      fx = job_x_ff + FACE_W'(pick[SLOT_X_HIGH]);
      fy = job_y_ff + FACE_W'(pick[SLOT_Y_HIGH]);
      fz = job_z_ff + FACE_W'(pick[SLOT_Z_HIGH]);
      if (pick[SLOT_Z_LOW] | pick[SLOT_Z_HIGH]) begin
         faxis = AXIS_Z;
      end else if (pick[SLOT_Y_LOW] | pick[SLOT_Y_HIGH]) begin
         faxis = AXIS_Y;
      end else begin
         faxis = AXIS_X;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // job coordinates and output beat payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_x_ff <= head_job.x;
         job_y_ff <= head_job.y;
         job_z_ff <= head_job.z;
      end
      if (emit) begin
         face_x_ff <= fx;
         face_y_ff <= fy;
         face_z_ff <= fz;
         axis_ff   <= faxis;
         last_ff   <= (rest == '0);
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.face_x    = face_x_ff;
   assign rsp.face_y    = face_y_ff;
   assign rsp.face_z    = face_z_ff;
   assign rsp.face_axis = axis_ff;
   assign rsp.last_face = last_ff;

`ifndef ASSERT_OFF
   a_loaded_job_has_faces: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (mask_ff != '0))
      else $error("serialiser loaded a job with no faces");

   a_emit_fills_output: assert property (@(posedge clock) disable iff (reset)
      emit |=> valid_ff)
      else $error("face beat lost on its way to the output register");
`endif

endmodule

@@ hw/rtl/voxel_boundary_face_extract_unit.sv @@
// ============================================================================
// voxel_boundary_face_extract_unit
// Boundary face extraction over a raster stream of voxel occupancy bits.
// ============================================================================
//
//   channel   dir  payload                                   beat taken when
//   req_chan  in   solid                                     valid & ready
//   rsp_chan  out  face_x, face_y, face_z, face_axis,        valid & ready
//                  last_face
//   csr_chan  in   index (0 dim_x, 1 dim_y, 2 dim_z), data   valid & ready
//
// One voxel is taken per cycle; it produces zero to six faces, sent one per
// cycle from the serialiser while the receiver is ready. The job queue (four
// deep) absorbs face bursts; the input stalls when the queued jobs plus the
// voxel in the classify stage reach the queue depth. A voxel beat passes the
// classify stage, job queue, serialiser mask and output register on its way
// to its first face beat. Reset clears the counters, queue and output; the
// row and slice stores are not cleared. Register writes are always taken.
//
module voxel_boundary_face_extract_unit #(
   parameter int MAX_DIM = vbfe_pkg::MAX_DIM_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   vbfe_req_if.sink   req_chan,
   vbfe_rsp_if.source rsp_chan,
   vbfe_csr_if.sink   csr_chan
);
   import vbfe_pkg::*;

   localparam int CW  = $clog2(MAX_DIM);
   localparam int EW0 = $clog2(MAX_DIM + 1);
   localparam int EW  = (DIM_W > EW0) ? DIM_W : EW0;

   logic [DIM_W-1:0]   dim_x_ff, dim_y_ff, dim_z_ff;
   logic [CW-1:0]      last_x, last_y, last_z;
   logic               csr_write;

   logic               q_push;
   logic               q_pop;
   face_job_type       push_job;
   face_job_type       head_job;
   queue_status_type   q_status;

   // highest index along an edge, with zero read as one and clamped to MAX_DIM
   function automatic logic [CW-1:0] last_index(input logic [DIM_W-1:0] dim);
      logic [EW-1:0] d;
      logic [CW-1:0] r;
      d = EW'(dim);
      if (d == '0) begin
         r = '0;
      end else if (d > EW'(MAX_DIM)) begin
         r = CW'(MAX_DIM - 1);
      end else begin
         r = CW'(d - EW'(1));
      end
      return r;
   endfunction

   assign last_x = last_index(dim_x_ff);
   assign last_y = last_index(dim_y_ff);
   assign last_z = last_index(dim_z_ff);

   // dimension registers
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid & csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= DIM_RESET;
         dim_y_ff <= DIM_RESET;
         dim_z_ff <= DIM_RESET;
      end else if (csr_write) begin
         unique case (csr_chan.index)
            CSR_DIM_X: dim_x_ff <= csr_chan.data;
            CSR_DIM_Y: dim_y_ff <= csr_chan.data;
            CSR_DIM_Z: dim_z_ff <= csr_chan.data;
            default:   ;
         endcase
      end
   end

   vbfe_front #(
      .MAX_DIM (MAX_DIM),
      .CW      (CW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .last_x   (last_x),
      .last_y   (last_y),
      .last_z   (last_z),
      .q_status (q_status),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   vbfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   vbfe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp      (rsp_chan)
   );

endmodule

@@ verif/tb_voxel_boundary_face_extract_unit.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_voxel_boundary_face_extract_unit
// Self-checking bench for the voxel boundary face extractor.
//
// Voxel bits are streamed in raster order against a behavioural face
// predictor that keeps its own copy of the row store, slice store, counters
// and dimension registers. Every face beat is checked field by field against
// the oldest expected face. A short directed table comes first: reset
// dimensions, a dimension shrink part way through a volume, the unused
// register index and an isolated corner voxel with all six faces. Then come
// small volumes with zero dimensions and random small volumes. The sender
// idles in bursts and the receiver stalls on a rotating pattern.
// ============================================================================
module tb_voxel_boundary_face_extract_unit;
   import vbfe_pkg::*;

   localparam int MAX_EDGE      = MAX_DIM_DEFAULT;
   localparam int DRAIN_CYCLES  = 12;
   localparam int RANDOM_TARGET = 75;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PLAN_N        = 21;
   localparam int TYPED_N       = 13;

   // Index with no register behind it; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [FACE_W-1:0] x;
      logic [FACE_W-1:0] y;
      logic [FACE_W-1:0] z;
      logic [AXIS_W-1:0] axis;
      logic              last;
   } face_beat_type;

   typedef enum logic {ROW_VOXEL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic                 solid;
      logic [CSR_IDX_W-1:0] index;
      logic [DIM_W-1:0]     data;
      logic                 typed;
      logic [2:0]           n_typed;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vbfe_req_if req_if();
   vbfe_rsp_if rsp_if();
   vbfe_csr_if csr_if();

   voxel_boundary_face_extract_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Directed table. Voxel rows marked typed carry their faces in typed_faces.
   // Reset dimensions first, then a shrink to 4x2x2 part way through row 0
   // which finishes that volume; the last voxel is an isolated corner.
   plan_row_type plan [PLAN_N] = '{
      '{ROW_VOXEL, 1'b1, CSR_DIM_X, 9'd0,   1'b1, 3'd3},
      '{ROW_VOXEL, 1'b0, CSR_DIM_X, 9'd0,   1'b1, 3'd1},
      '{ROW_VOXEL, 1'b0, CSR_DIM_X, 9'd0,   1'b1, 3'd0},
      '{ROW_VOXEL, 1'b1, CSR_DIM_X, 9'd0,   1'b1, 3'd3},
      '{ROW_CSR,   1'b0, CSR_SPARE, 9'd511, 1'b0, 3'd0},
      '{ROW_CSR,   1'b0, CSR_DIM_X, 9'd4,   1'b0, 3'd0},
      '{ROW_CSR,   1'b0, CSR_DIM_Y, 9'd2,   1'b0, 3'd0},
      '{ROW_CSR,   1'b0, CSR_DIM_Z, 9'd2,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b1, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b1, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b0, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b1, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b0, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b0, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b1, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b0, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b0, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b1, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b0, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b0, CSR_DIM_X, 9'd0,   1'b0, 3'd0},
      '{ROW_VOXEL, 1'b1, CSR_DIM_X, 9'd0,   1'b1, 3'd6}
   };

   face_beat_type typed_faces [TYPED_N] = '{
      // first solid voxel at the origin: three low faces
      '{9'd0, 9'd0, 9'd0, AXIS_X, 1'b0},
      '{9'd0, 9'd0, 9'd0, AXIS_Y, 1'b0},
      '{9'd0, 9'd0, 9'd0, AXIS_Z, 1'b1},
      // empty after solid: x face only
      '{9'd1, 9'd0, 9'd0, AXIS_X, 1'b1},
      // solid after empty on the bottom row
      '{9'd3, 9'd0, 9'd0, AXIS_X, 1'b0},
      '{9'd3, 9'd0, 9'd0, AXIS_Y, 1'b0},
      '{9'd3, 9'd0, 9'd0, AXIS_Z, 1'b1},
      // isolated corner voxel of the 4x2x2 volume
      '{9'd3, 9'd1, 9'd1, AXIS_X, 1'b0},
      '{9'd4, 9'd1, 9'd1, AXIS_X, 1'b0},
      '{9'd3, 9'd1, 9'd1, AXIS_Y, 1'b0},
      '{9'd3, 9'd2, 9'd1, AXIS_Y, 1'b0},
      '{9'd3, 9'd1, 9'd1, AXIS_Z, 1'b0},
      '{9'd3, 9'd1, 9'd2, AXIS_Z, 1'b1}
   };

   // Predictor state
   logic [DIM_W-1:0] dim_x_cfg = DIM_RESET;
   logic [DIM_W-1:0] dim_y_cfg = DIM_RESET;
   logic [DIM_W-1:0] dim_z_cfg = DIM_RESET;
   logic             row_bits   [MAX_EDGE];
   logic             slice_bits [MAX_EDGE*MAX_EDGE];
   logic             left_bit = 1'b0;
   int               pos_x = 0;
   int               pos_y = 0;
   int               pos_z = 0;
   face_beat_type    voxel_faces [SLOT_N];

   face_beat_type    face_expect_q [$];
   int               fail_count  = 0;
   int               cycle_count = 0;
   int               typed_pos   = 0;
   int               burst_left  = 0;
   bit               idle_sender = 1'b1;
   logic [15:0]      ready_pattern = 16'hFFFF;
   logic [3:0]       ready_step    = 4'd0;

   // Clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int eff_dim(input logic [DIM_W-1:0] d);
      if (d == 0)
         return 1;
      if (d > MAX_EDGE)
         return MAX_EDGE;
      return d;
   endfunction

   function automatic face_beat_type make_face(input int x, input int y, input int z,
                                               input logic [AXIS_W-1:0] axis);
      face_beat_type f;
      f.x    = FACE_W'(x);
      f.y    = FACE_W'(y);
      f.z    = FACE_W'(z);
      f.axis = axis;
      f.last = 1'b0;
      return f;
   endfunction

   // Faces of one voxel into voxel_faces, in output order; advances the state
   function automatic int predict_faces(input logic solid_bit);
      int   dx, dy, dz, x, y, z, n;
      logic nx, ny, nz;
      dx = eff_dim(dim_x_cfg);
      dy = eff_dim(dim_y_cfg);
      dz = eff_dim(dim_z_cfg);
      x  = pos_x % MAX_EDGE;
      y  = pos_y % MAX_EDGE;
      z  = pos_z;
      // low edges count as empty neighbours
      nx = (x == 0) ? 1'b0 : left_bit;
      ny = (y == 0) ? 1'b0 : row_bits[x];
      nz = (z == 0) ? 1'b0 : slice_bits[y*MAX_EDGE + x];
      n  = 0;
      if (solid_bit != nx) begin
         voxel_faces[n] = make_face(x, y, z, AXIS_X);
         n++;
      end
      if (solid_bit && x == dx - 1) begin
         voxel_faces[n] = make_face(x + 1, y, z, AXIS_X);
         n++;
      end
      if (solid_bit != ny) begin
         voxel_faces[n] = make_face(x, y, z, AXIS_Y);
         n++;
      end
      if (solid_bit && y == dy - 1) begin
         voxel_faces[n] = make_face(x, y + 1, z, AXIS_Y);
         n++;
      end
      if (solid_bit != nz) begin
         voxel_faces[n] = make_face(x, y, z, AXIS_Z);
         n++;
      end
      if (solid_bit && z == dz - 1) begin
         voxel_faces[n] = make_face(x, y, z + 1, AXIS_Z);
         n++;
      end
      if (n > 0)
         voxel_faces[n-1].last = 1'b1;

      left_bit                  = solid_bit;
      row_bits[x]               = solid_bit;
      slice_bits[y*MAX_EDGE + x] = solid_bit;

      // raster advance, wrapping at the end of the volume
      if (x + 1 >= dx) begin
         pos_x = 0;
         if (y + 1 >= dy) begin
            pos_y = 0;
            pos_z = (z + 1 >= dz) ? 0 : z + 1;
         end else begin
            pos_y = y + 1;
         end
      end else begin
         pos_x = x + 1;
      end
      return n;
   endfunction

   function automatic void check_field(input string field, input logic [FACE_W-1:0] want,
                                       input logic [FACE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   // One voxel beat; random-length bursts, random gaps only with idle_sender set
   task automatic send_voxel(input logic solid_bit, input logic typed,
                             input logic [2:0] n_typed);
      int n;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (idle_sender) begin
            gap = $urandom_range(1, 5);
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.solid <= solid_bit;
      do @(posedge clock); while (!req_if.ready);
      n = predict_faces(solid_bit);
      if (typed) begin
         repeat (n_typed) begin
            face_expect_q = {face_expect_q, typed_faces[typed_pos]};
            typed_pos++;
         end
      end else begin
         for (int i = 0; i < n; i++)
            face_expect_q = {face_expect_q, voxel_faces[i]};
      end
   endtask

   task automatic stop_stream();
      @(negedge clock);
      req_if.valid <= 1'b0;
      burst_left = 0;
   endtask

   // Wait for every expected face, then let zero-face voxels drain
   task automatic settle();
      while (face_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_DIM_X: dim_x_cfg = value;
         CSR_DIM_Y: dim_y_cfg = value;
         CSR_DIM_Z: dim_z_cfg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Set the dimensions while idle and stream one whole volume of random voxels
   task automatic run_volume(input logic [DIM_W-1:0] vx, input logic [DIM_W-1:0] vy,
                             input logic [DIM_W-1:0] vz, output int sent);
      int density;
      stop_stream();
      settle();
      write_csr(CSR_DIM_X, vx);
      write_csr(CSR_DIM_Y, vy);
      write_csr(CSR_DIM_Z, vz);
      idle_sender = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
         0:       density = 0;
         1:       density = 20;
         2:       density = 50;
         3:       density = 80;
         default: density = 100;
      endcase
      sent = eff_dim(vx) * eff_dim(vy) * eff_dim(vz);
      for (int i = 0; i < sent; i++)
         send_voxel($urandom_range(0, 99) < density, 1'b0, 3'd0);
   endtask

   // Receiver stalls on a rotating 16-bit pattern, renewed at random
   always @(negedge clock) begin
      if (ready_step == 4'd15 && $urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 3))
            0:       ready_pattern <= 16'hFFFF;
            1:       ready_pattern <= 16'($urandom) | 16'h0001;
            2:       ready_pattern <= 16'($urandom & $urandom) | 16'h0100;
            default: ready_pattern <= 16'h00FF;
         endcase
      end
      rsp_if.ready <= ready_pattern[ready_step];
      ready_step   <= ready_step + 4'd1;
   end

   // Face beat checker
   always @(posedge clock) begin
      face_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (face_expect_q.size() == 0) begin
            $display("%0t: expected no face got x %0d y %0d z %0d axis %0d last %0b",
                     $time, rsp_if.face_x, rsp_if.face_y, rsp_if.face_z,
                     rsp_if.face_axis, rsp_if.last_face);
            fail_count++;
         end else begin
            want = face_expect_q.pop_front();
            check_field("face_x", want.x, rsp_if.face_x);
            check_field("face_y", want.y, rsp_if.face_y);
            check_field("face_z", want.z, rsp_if.face_z);
            check_field("face_axis", FACE_W'(want.axis), FACE_W'(rsp_if.face_axis));
            check_field("last_face", FACE_W'(want.last), FACE_W'(rsp_if.last_face));
         end
      end
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("voxel_boundary_face_extract_unit regression: fail");
      $finish;
   end

   // Stimulus
   initial begin
      int sent;
      int random_voxels;
      req_if.valid = 1'b0;
      req_if.solid = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_DIM_X;
      csr_if.data  = '0;
      rsp_if.ready = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CSR) begin
            stop_stream();
            settle();
            write_csr(plan[r].index, plan[r].data);
         end else begin
            send_voxel(plan[r].solid, plan[r].typed, plan[r].n_typed);
         end
      end

      // small volumes with zero dimensions; zero acts as one
      run_volume(9'd0, 9'd3, 9'd2, sent);
      run_volume(9'd5, 9'd0, 9'd1, sent);
      run_volume(9'd2, 9'd2, 9'd0, sent);

      // random small volumes
      random_voxels = 0;
      while (random_voxels < RANDOM_TARGET) begin
         run_volume($urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(0, 4), sent);
         random_voxels += sent;
      end

      stop_stream();
      settle();
      if (fail_count == 0)
         $display("voxel_boundary_face_extract_unit regression: pass");
      else
         $display("voxel_boundary_face_extract_unit regression: fail");
      $finish;
   end

endmodule
